// ===== rtl/core/ses_pkg.sv =====
package ses_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [15:0] entry_score;
    logic [15:0] entry_tag;
    logic        last_entry;
  } in_item_t;

  typedef struct packed {
    logic [15:0] sorted_tag;
    logic [15:0] sorted_score;
    logic        end_of_run;
    logic        dropped_flag;
  } out_item_t;

  // One stored entry: score and tag move together.
  typedef struct packed {
    logic [15:0] score;
    logic [15:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath commands.
  typedef struct packed {
    logic load;        // store the incoming item or note the overflow
    logic rd_i;        // read entry i, point j at i+1
    logic ld_cur;      // hold entry i in the working register, read entry j
    logic cmp;         // compare entry j with the working entry, swap if greater
    logic wb;          // write the working entry back to slot i, advance i
    logic emit_start;  // read slot 0, point j at 0
    logic emit;        // show slot j, read slot j+1
    logic clear;       // drop the set count and overflow mark, reset i
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic i_done;      // i+1 reaches the set count: sort finished
    logic j_last;      // j is the last occupied slot
  } sts_t;

endpackage

// ===== rtl/core/ses_ram.sv =====
module ses_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ses_ctrl.sv =====
module ses_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          last_entry,
  input  ses_pkg::sts_t sts,
  output ses_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);

  import ses_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_IRD  = 3'd1;
  localparam logic [2:0] S_ILD  = 3'd2;
  localparam logic [2:0] S_JCMP = 3'd3;
  localparam logic [2:0] S_IWB  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_entry) begin
            state_nxt = S_IRD;
          end
        end
      end
      S_IRD: begin
        if (sts.i_done) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          cmd.rd_i  = 1'b1;
          state_nxt = S_ILD;
        end
      end
      S_ILD: begin
        cmd.ld_cur = 1'b1;
        state_nxt  = S_JCMP;
      end
      S_JCMP: begin
        cmd.cmp = 1'b1;
        if (sts.j_last) begin
          state_nxt = S_IWB;
        end
      end
      S_IWB: begin
        cmd.wb    = 1'b1;
        state_nxt = S_IRD;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.j_last) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT);

endmodule

// ===== rtl/core/ses_dp.sv =====
module ses_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  ses_pkg::in_item_t  in_item,
  input  ses_pkg::cmd_t      cmd,
  output ses_pkg::sts_t      sts,
  output ses_pkg::out_item_t out_item
);

  import ses_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  entry_t           cur_r, cur_nxt;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;
  logic [IDX_W-1:0]   raddr;
  logic [ENTRY_W-1:0] rdata_raw;
  entry_t             rdata;
  logic               has_room;
  logic               greater;

  assign rdata    = entry_t'(rdata_raw);
  assign has_room = (count_r < CNT_W'(CAPACITY));
  assign greater  = (rdata.score > cur_r.score);

  ses_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cur_nxt   = cur_r;
    we        = 1'b0;
    waddr     = j_r;
    wdata     = cur_r;
    raddr     = j_r;

    if (cmd.load) begin
      if (has_room) begin
        we          = 1'b1;
        waddr       = count_r[IDX_W-1:0];
        wdata.score = in_item.entry_score;
        wdata.tag   = in_item.entry_tag;
        count_nxt   = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.rd_i) begin
      raddr = i_r;
      j_nxt = i_r + IDX_W'(1);
    end
    if (cmd.ld_cur) begin
      cur_nxt = rdata;
      raddr   = j_r;
    end
    if (cmd.cmp) begin
      // Swap: the smaller working entry drops into slot j.
      if (greater) begin
        we      = 1'b1;
        waddr   = j_r;
        wdata   = cur_r;
        cur_nxt = rdata;
      end
      raddr = j_r + IDX_W'(1);
      j_nxt = j_r + IDX_W'(1);
    end
    if (cmd.wb) begin
      we    = 1'b1;
      waddr = i_r;
      wdata = cur_r;
      i_nxt = i_r + IDX_W'(1);
    end
    if (cmd.emit_start) begin
      raddr = '0;
      j_nxt = '0;
    end
    if (cmd.emit) begin
      raddr = j_r + IDX_W'(1);
      j_nxt = j_r + IDX_W'(1);
    end
    if (cmd.clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      i_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign sts.i_done = ((CNT_W'(i_r) + CNT_W'(1)) >= count_r);
  assign sts.j_last = (CNT_W'(j_r) == (count_r - CNT_W'(1)));

  assign out_item.sorted_tag   = rdata.tag;
  assign out_item.sorted_score = rdata.score;
  assign out_item.end_of_run   = sts.j_last;
  assign out_item.dropped_flag = ovf_r;

endmodule

// ===== rtl/core/score_exchange_sorter.sv =====
// Collects up to CAPACITY (16) scored entries, one per accepted start, until an
// entry marked last arrives, then sorts the set by descending score and plays
// it out. The sort is a classic exchange sort: for each slot i, every later
// slot j swaps with i only when its score is strictly greater, so entries with
// equal scores keep the exact exchange-sort order. Entries that arrive while
// the store is full are dropped, and dropped_flag is then high on every result
// of that set. An entry without the last mark leaves busy low. After the last
// entry busy stays high for the sort and the play-out: for each slot i the
// sort reads slot i, takes it as the working entry, compares it with each
// later slot in turn and writes it back to slot i; the play-out then shows
// one result per cycle. The pace of the sort is set by the single read port
// of the entry store, which each compare step uses once. The receiver cannot
// stall: each result is shown for exactly one cycle with out_valid high, and
// end_of_run marks the last one.
module score_exchange_sorter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ses_pkg::in_item_t  in_item,
  output logic               out_valid,
  output ses_pkg::out_item_t out_item
);

  import ses_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the load, sort and play-out phases.
  ses_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .last_entry (in_item.last_entry),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid)
  );

  // Hold the entry store, the working entry and the slot counters.
  ses_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule
